### rtl/core/brld_pkg.sv
// ----------------------------------------------------------------------------
// brld_pkg
// Types and constants shared by the bit run-length decoder modules.
// ----------------------------------------------------------------------------
package brld_pkg;

    // input function codes
    localparam logic [1:0] FUNC_DATA   = 2'd0;
    localparam logic [1:0] FUNC_FINISH = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // result fields
    localparam int              REPEAT_W   = 22;
    localparam logic [21:0]     REPEAT_MAX = '1;
    localparam logic [7:0]      BYTE_ONES  = 8'hFF;

    // queue sizes
    localparam int IN_Q_DEPTH  = 4;
    localparam int IN_Q_AW     = 2;
    localparam int OUT_Q_DEPTH = 4;
    localparam int OUT_Q_AW    = 2;

    // command kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_FINISH,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [7:0]          byte_value;
        logic [REPEAT_W-1:0] repeat_count;
        logic                status;
        logic                last;
    } t_res;

    // decoder sequencer states
    typedef enum logic [1:0] {
        ST_NEXT,
        ST_BIT,
        ST_WHOLE
    } t_back_state;

endpackage

### rtl/core/brld_front.sv
// ----------------------------------------------------------------------------
// brld_front
// Accepts input requests, classifies the function code and queues commands.
// ----------------------------------------------------------------------------
module brld_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    i_func,
    input  logic [7:0]    i_data_byte,
    output logic          o_cmd_vld,
    output brld_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import brld_pkg::*;

    t_cmd                 r_mem [IN_Q_DEPTH];
    logic [IN_Q_AW-1:0]   r_wptr, n_wptr;
    logic [IN_Q_AW-1:0]   r_rptr, n_rptr;
    logic [IN_Q_AW:0]     r_count, n_count;
    logic                 accept;
    logic                 keep;
    logic                 deq;
    t_cmd                 cmd_in;

    // classify the incoming function code; the unused code is dropped
    always_comb begin
        keep        = 1'b1;
        cmd_in.data = i_data_byte;
        cmd_in.kind = CMD_DATA;
        unique case (i_func)
            FUNC_DATA:   cmd_in.kind = CMD_DATA;
            FUNC_FINISH: cmd_in.kind = CMD_FINISH;
            FUNC_CLEAR:  cmd_in.kind = CMD_CLEAR;
            default:     keep = 1'b0;
        endcase
    end

    assign full      = (r_count == (IN_Q_AW+1)'(IN_Q_DEPTH));
    assign accept    = push && !full && keep;
    assign deq       = i_cmd_pop && (r_count != '0);
    assign o_cmd_vld = (r_count != '0);
    assign o_cmd     = r_mem[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr  = accept ? r_wptr + IN_Q_AW'(1) : r_wptr;
        n_rptr  = deq ? r_rptr + IN_Q_AW'(1) : r_rptr;
        n_count = r_count + (IN_Q_AW+1)'(accept) - (IN_Q_AW+1)'(deq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wptr] <= cmd_in;
        end
    end

endmodule

### rtl/core/brld_back.sv
// ----------------------------------------------------------------------------
// brld_back
// Walks each command bit by bit, decodes run prefixes and counts, packs
// pixels into bytes and writes results to the output queue.
// ----------------------------------------------------------------------------
module brld_back #(
    parameter int COUNT_BITS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_vld,
    input  brld_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_res_wr,
    output brld_pkg::t_res o_res,
    input  logic           i_res_full
);
    import brld_pkg::*;

    localparam int CW = $clog2(COUNT_BITS + 1);
    localparam int TW = COUNT_BITS + 1;
    localparam int EW = (TW > REPEAT_W) ? TW : REPEAT_W;
    localparam logic [CW-1:0] PREFIX_LIMIT = CW'(COUNT_BITS - 2);

    t_back_state          r_state, n_state;
    logic                 r_started, n_started;
    logic                 r_run_value, n_run_value;
    logic                 r_reading, n_reading;
    logic [CW-1:0]        r_prefix, n_prefix;
    logic [CW-1:0]        r_cbr, n_cbr;
    logic [COUNT_BITS-1:0] r_accum, n_accum;
    logic [7:0]           r_pbyte, n_pbyte;
    logic [2:0]           r_pbits, n_pbits;
    logic                 r_err, n_err;
    logic [7:0]           r_shift, n_shift;
    logic [3:0]           r_left, n_left;
    logic                 r_pend_vld, n_pend_vld;
    t_res                 r_pend, n_pend;
    t_res                 r_whole, n_whole;

    logic                 bit_in;
    logic [COUNT_BITS-1:0] accum_nx;
    logic [CW-1:0]        cbr_nx;
    logic                 run_end;
    logic [TW-1:0]        total;
    logic                 total_lt8;
    logic [EW-1:0]        whole;
    logic [EW-1:0]        whole_sel;
    logic [REPEAT_W-1:0]  rep_sat;
    logic [3:0]           hi_sh;
    logic [7:0]           lo_mask;
    logic [7:0]           hi_mask;
    logic [7:0]           fill;
    t_res                 first_res;
    t_res                 second_res;
    t_res                 err_res;
    t_res                 step_res;
    logic                 step_res_vld;
    logic                 step_two;
    logic                 res_room;
    logic                 do_clear;

    // run arithmetic for the bit at the head of the shift register
    assign bit_in    = r_shift[7];
    assign accum_nx  = {r_accum[COUNT_BITS-2:0], bit_in};
    assign cbr_nx    = r_cbr + CW'(1);
    assign run_end   = r_reading &&
                       ({1'b0, cbr_nx} >= ({1'b0, r_prefix} + (CW+1)'(2)));
    assign total     = TW'(accum_nx) + TW'(1) + TW'(r_pbits);
    assign total_lt8 = (total < TW'(8));
    assign whole     = EW'(total >> 3);
    assign whole_sel = (r_pbits != 3'd0) ? whole - EW'(1) : whole;
    assign rep_sat   = (whole_sel > EW'(REPEAT_MAX)) ? REPEAT_MAX
                                                     : whole_sel[REPEAT_W-1:0];
    assign hi_sh     = 4'd8 - {1'b0, total[2:0]};
    assign lo_mask   = BYTE_ONES >> r_pbits;
    assign hi_mask   = BYTE_ONES << hi_sh;
    assign fill      = r_run_value ? BYTE_ONES : 8'h00;
    assign res_room  = !r_pend_vld || !i_res_full;

    // candidate results of a finished run and of a prefix overflow
    always_comb begin
        second_res.byte_value   = fill;
        second_res.repeat_count = rep_sat;
        second_res.status       = 1'b0;
        second_res.last         = 1'b0;

        if (r_pbits != 3'd0) begin
            first_res.byte_value   = r_pbyte | (r_run_value ? lo_mask : 8'h00);
            first_res.repeat_count = REPEAT_W'(1);
            first_res.status       = 1'b0;
            first_res.last         = 1'b0;
        end else begin
            first_res = second_res;
        end

        err_res.byte_value   = 8'h00;
        err_res.repeat_count = '0;
        err_res.status       = 1'b1;
        err_res.last         = 1'b0;
    end

    // classify what the current bit produces
    always_comb begin
        step_res_vld = 1'b0;
        step_res     = first_res;
        step_two     = 1'b0;
        if (!r_err && r_started) begin
            if (!r_reading) begin
                if (bit_in && (r_prefix >= PREFIX_LIMIT)) begin
                    step_res_vld = 1'b1;
                    step_res     = err_res;
                end
            end else if (run_end && !total_lt8) begin
                step_res_vld = 1'b1;
                step_two     = (r_pbits != 3'd0) && (whole_sel != '0);
            end
        end
    end

    // sequencer: next state, decoder state and queue writes
    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_run_value = r_run_value;
        n_reading   = r_reading;
        n_prefix    = r_prefix;
        n_cbr       = r_cbr;
        n_accum     = r_accum;
        n_pbyte     = r_pbyte;
        n_pbits     = r_pbits;
        n_err       = r_err;
        n_shift     = r_shift;
        n_left      = r_left;
        n_pend_vld  = r_pend_vld;
        n_pend      = r_pend;
        n_whole     = r_whole;
        o_cmd_pop   = 1'b0;
        o_res_wr    = 1'b0;
        o_res       = r_pend;
        do_clear    = 1'b0;

        unique case (r_state)
            ST_NEXT: begin
                // close the previous item, then take the next command
                if (r_pend_vld && !i_res_full) begin
                    o_res_wr      = 1'b1;
                    o_res.last    = 1'b1;
                    n_pend_vld    = 1'b0;
                end
                if (res_room && i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_DATA: begin
                            n_shift = i_cmd.data;
                            n_left  = 4'd8;
                            n_state = ST_BIT;
                        end
                        CMD_FINISH: begin
                            if (r_pbits != 3'd0) begin
                                n_pend.byte_value   = r_pbyte;
                                n_pend.repeat_count = REPEAT_W'(1);
                                n_pend.status       = 1'b0;
                                n_pend.last         = 1'b0;
                                n_pend_vld          = 1'b1;
                            end
                            do_clear = 1'b1;
                        end
                        CMD_CLEAR: begin
                            do_clear = 1'b1;
                        end
                        default: begin
                            do_clear = 1'b0;
                        end
                    endcase
                end
            end

            ST_BIT: begin
                if (!step_res_vld || res_room) begin
                    // decoder state for one compressed bit
                    if (!r_err) begin
                        if (!r_started) begin
                            n_started   = 1'b1;
                            n_run_value = bit_in;
                        end else if (!r_reading) begin
                            if (bit_in) begin
                                if (r_prefix >= PREFIX_LIMIT) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_prefix = r_prefix + CW'(1);
                                end
                            end else begin
                                n_reading = 1'b1;
                                n_accum   = '0;
                                n_cbr     = '0;
                            end
                        end else begin
                            n_accum = accum_nx;
                            n_cbr   = cbr_nx;
                            if (run_end) begin
                                n_pbits = total[2:0];
                                if (total_lt8) begin
                                    n_pbyte = r_pbyte |
                                              (r_run_value ? (lo_mask & hi_mask) : 8'h00);
                                end else begin
                                    n_pbyte = r_run_value ? hi_mask : 8'h00;
                                end
                                n_run_value = !r_run_value;
                                n_reading   = 1'b0;
                                n_prefix    = '0;
                                n_cbr       = '0;
                            end
                        end
                    end

                    // hand the older pending result to the queue
                    if (step_res_vld) begin
                        if (r_pend_vld) begin
                            o_res_wr = 1'b1;
                        end
                        n_pend     = step_res;
                        n_pend_vld = 1'b1;
                    end

                    n_shift = {r_shift[6:0], 1'b0};
                    n_left  = r_left - 4'd1;
                    if (step_two) begin
                        n_whole = second_res;
                        n_state = ST_WHOLE;
                    end else if (r_left == 4'd1) begin
                        n_state = ST_NEXT;
                    end
                end
            end

            ST_WHOLE: begin
                // second result of a run: the whole bytes of the run value
                if (!i_res_full) begin
                    o_res_wr = 1'b1;
                    n_pend   = r_whole;
                    n_state  = (r_left == 4'd0) ? ST_NEXT : ST_BIT;
                end
            end

            default: begin
                n_state = ST_NEXT;
            end
        endcase

        // finish and clear return the decoder to its reset state
        if (do_clear) begin
            n_started   = 1'b0;
            n_run_value = 1'b0;
            n_reading   = 1'b0;
            n_prefix    = '0;
            n_cbr       = '0;
            n_accum     = '0;
            n_pbyte     = 8'h00;
            n_pbits     = 3'd0;
            n_err       = 1'b0;
        end
    end

    // control and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_NEXT;
            r_started   <= 1'b0;
            r_run_value <= 1'b0;
            r_reading   <= 1'b0;
            r_prefix    <= '0;
            r_cbr       <= '0;
            r_accum     <= '0;
            r_pbyte     <= 8'h00;
            r_pbits     <= 3'd0;
            r_err       <= 1'b0;
            r_left      <= 4'd0;
            r_pend_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_run_value <= n_run_value;
            r_reading   <= n_reading;
            r_prefix    <= n_prefix;
            r_cbr       <= n_cbr;
            r_accum     <= n_accum;
            r_pbyte     <= n_pbyte;
            r_pbits     <= n_pbits;
            r_err       <= n_err;
            r_left      <= n_left;
            r_pend_vld  <= n_pend_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_pend  <= n_pend;
        r_whole <= n_whole;
    end

endmodule

### rtl/core/brld_outq.sv
// ----------------------------------------------------------------------------
// brld_outq
// Result queue between the decoder and the receiver.
// ----------------------------------------------------------------------------
module brld_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  brld_pkg::t_res i_res,
    output logic           o_full,
    output logic           empty,
    input  logic           pop,
    output brld_pkg::t_res o_res
);
    import brld_pkg::*;

    t_res                  r_mem [OUT_Q_DEPTH];
    logic [OUT_Q_AW-1:0]   r_wptr, n_wptr;
    logic [OUT_Q_AW-1:0]   r_rptr, n_rptr;
    logic [OUT_Q_AW:0]     r_count, n_count;
    logic                  enq;
    logic                  deq;

    assign o_full = (r_count == (OUT_Q_AW+1)'(OUT_Q_DEPTH));
    assign empty  = (r_count == '0);
    assign enq    = i_wr && !o_full;
    assign deq    = pop && !empty;
    assign o_res  = r_mem[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr  = enq ? r_wptr + OUT_Q_AW'(1) : r_wptr;
        n_rptr  = deq ? r_rptr + OUT_Q_AW'(1) : r_rptr;
        n_count = r_count + (OUT_Q_AW+1)'(enq) - (OUT_Q_AW+1)'(deq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wptr] <= i_res;
        end
    end

endmodule

### rtl/core/bit_run_length_decoder.sv
// ----------------------------------------------------------------------------
// bit_run_length_decoder
// Decodes a bit run-length stream into (byte value, repeat count) results.
// Input side is a queue: write a request with push while full is low. func 0
// carries a compressed byte, func 1 flushes a carried partial byte and resets
// the decoder, func 2 resets without output, func 3 is dropped.
// Result side is a queue: while empty is low the oldest result is on the
// o_ ports; pop takes it. o_last marks the final result of a request.
// The decoder walks a data byte one compressed bit at a time, then closes the
// request; a run that yields both a partial byte and a whole-byte result also
// passes through a second-result state. The decoder takes a new command only
// after it is through with the current one; a 4-deep command queue lets input
// keep arriving while it works. A result is held until the next result of its
// request forms or the request closes, and only then is written to the result
// queue.
// When the receiver stalls, the 4-deep result queue fills, the decoder
// halts, and then the command queue fills and full rises.
// Reset empties both queues and clears all decoder state.
// ----------------------------------------------------------------------------
module bit_run_length_decoder #(
    parameter int COUNT_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_byte_value,
    output logic [21:0] o_repeat_count,
    output logic        o_status,
    output logic        o_last
);
    import brld_pkg::*;

    logic cmd_vld;
    t_cmd cmd;
    logic cmd_pop;
    logic res_wr;
    t_res res_in;
    logic res_full;
    t_res res_out;

    // front: accept and classify requests
    brld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .o_cmd_vld   (cmd_vld),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back: bit-serial run decoder
    brld_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_res_wr   (res_wr),
        .o_res      (res_in),
        .i_res_full (res_full)
    );

    // result queue
    brld_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_res   (res_in),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_out)
    );

    assign o_byte_value   = res_out.byte_value;
    assign o_repeat_count = res_out.repeat_count;
    assign o_status       = res_out.status;
    assign o_last         = res_out.last;

endmodule
